/* rtl/core/lps_pkg.sv */
`default_nettype none
package lps_pkg;

  localparam logic [3:0] USER_Q = 4'd15;
  localparam logic [3:0] WIN_Q  = 4'd14;
  localparam logic [3:0] LOW_SYS_Q = 4'd13;

  localparam logic [2:0] ACT_START_SYS  = 3'd0;
  localparam logic [2:0] ACT_START_USER = 3'd1;
  localparam logic [2:0] ACT_STOP       = 3'd2;
  localparam logic [2:0] ACT_QUANTUM    = 3'd3;
  localparam logic [2:0] ACT_NICE       = 3'd4;
  localparam logic [2:0] ACT_BALANCE    = 3'd5;
  // unassigned codes, accepted as no-ops
  localparam logic [2:0] ACT_SPARE_LO   = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI   = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOT_USE = 2'd1;
  localparam logic [1:0] ST_BUSY    = 2'd2;
  localparam logic [1:0] ST_BAD_PRI = 2'd3;

  localparam int unsigned RND_BITS = 32;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_EMIT,
    S_SUM,
    S_DIV,
    S_WALK,
    S_BAL,
    S_FINAL
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input word
    logic decode;     // apply single-slot action
    logic clr_scan;   // reset scan index and accumulators
    logic sum_step;
    logic div_start;
    logic div_step;
    logic walk_step;
    logic bal_step;
    logic set_final;
    logic out_fire;   // never set by the controller; unused
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic emit_rec;     // decode produced a record
    logic go_lottery;   // decode asks for a lottery
    logic go_balance;
    logic scan_done;
    logic total_zero;
    logic div_done;
    logic step_emit;    // current walk/balance step produced a record
  } stat_t;

endpackage
`default_nettype wire

/* rtl/core/lps_datapath.sv */
`default_nettype none
module lps_datapath #(
  parameter int unsigned SLOTS       = 32,
  parameter int unsigned TICKET_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [15:0]            cfg_wdata_i,
  input  wire logic [2:0]             action_i,
  input  wire logic [4:0]             slot_i,
  input  wire logic [4:0]             ceil_req_i,
  input  wire logic signed [15:0]     nice_delta_i,
  input  wire logic [31:0]            random_i,
  input  wire lps_pkg::cmd_t          cmd_i,
  output lps_pkg::stat_t              stat_o,
  output logic                        kind_o,
  output logic [4:0]                  out_slot_o,
  output logic [3:0]                  new_priority_o,
  output logic [1:0]                  status_o,
  output logic                        last_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned TW = TICKET_BITS + CW;   // ticket total width
  localparam int unsigned DW = (TW > 32) ? TW : 32;
  // nice sum: wide enough for tickets plus a full 16-bit delta, with sign
  localparam int unsigned NW = ((TICKET_BITS > 16) ? TICKET_BITS : 16) + 2;
  localparam logic [TICKET_BITS-1:0] TMAX = {TICKET_BITS{1'b1}};

  logic [SLOTS-1:0]       use_q, sys_q;
  logic [3:0]             pri_q  [SLOTS];
  logic [3:0]             ceil_q [SLOTS];
  logic [TICKET_BITS-1:0] tix_q  [SLOTS];
  logic [15:0]            init_q;

  logic [2:0]         act_q;
  logic [4:0]         slot_q;
  logic [4:0]         maxp_q;
  logic signed [15:0] delta_q;
  logic [31:0]        rnd_q;

  logic [CW-1:0] idx_q;
  logic [TW-1:0] total_q;
  logic [DW-1:0] rem_q;
  logic [5:0]    dcnt_q;
  logic signed [TW+1:0] draw_q;

  logic       okind_q;
  logic [4:0] oslot_q;
  logic [3:0] opri_q;
  logic [1:0] ost_q;
  logic       emit_q, lot_q, bal_q;

  wire          valid_s = {1'b0, slot_q} < 6'(SLOTS);
  wire [IW-1:0] si = slot_q[IW-1:0];
  wire          used = valid_s && use_q[si];
  wire [IW-1:0] ii = idx_q[IW-1:0];
  wire          in_lot = use_q[ii] && !sys_q[ii] && pri_q[ii] == lps_pkg::USER_Q;
  wire [TICKET_BITS-1:0] init_sat =
      (TICKET_BITS < 16 && (init_q >> TICKET_BITS) != 16'd0) ? TMAX
                                                             : TICKET_BITS'(init_q);
  wire signed [NW-1:0] nice_sum =
      $signed(NW'(tix_q[si])) + NW'(delta_q);
  wire [DW:0] trial = {rem_q[DW-2:0], rnd_q[31]} - (DW+1)'(total_q);
  wire signed [TW+1:0] draw_n = draw_q - $signed((TW+2)'(tix_q[ii]));
  wire bal_hit = use_q[ii] && pri_q[ii] > ceil_q[ii] && pri_q[ii] < lps_pkg::WIN_Q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= 16'd20;
    end else if (cfg_we_i) begin
      init_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_q <= '0;
      sys_q <= '0;
      for (int k = 0; k < SLOTS; k++) begin
        pri_q[k]  <= '0;
        ceil_q[k] <= '0;
        tix_q[k]  <= '0;
      end
      act_q   <= '0;
      slot_q  <= '0;
      maxp_q  <= '0;
      delta_q <= '0;
      rnd_q   <= '0;
      total_q <= '0;
      rem_q   <= '0;
      draw_q  <= '0;
      okind_q <= 1'b0;
      oslot_q <= '0;
      opri_q  <= '0;
      ost_q   <= lps_pkg::ST_OK;
      emit_q <= 1'b0;
      lot_q  <= 1'b0;
      bal_q  <= 1'b0;
      idx_q  <= '0;
      dcnt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        act_q   <= action_i;
        slot_q  <= slot_i;
        maxp_q  <= ceil_req_i;
        delta_q <= nice_delta_i;
        rnd_q   <= random_i;
      end
      if (cmd_i.decode) begin
        emit_q  <= 1'b0;
        lot_q   <= 1'b0;
        bal_q   <= 1'b0;
        okind_q <= 1'b0;
        oslot_q <= slot_q;
        ost_q   <= lps_pkg::ST_OK;
        unique case (act_q)
          lps_pkg::ACT_START_SYS, lps_pkg::ACT_START_USER: begin
            if (!valid_s) ost_q <= lps_pkg::ST_NOT_USE;
            else if (used) ost_q <= lps_pkg::ST_BUSY;
            else if (maxp_q[4]) ost_q <= lps_pkg::ST_BAD_PRI;
            else begin
              ceil_q[si] <= maxp_q[3:0];
              tix_q[si]  <= init_sat;
              sys_q[si]  <= act_q == lps_pkg::ACT_START_SYS;
              pri_q[si]  <= (act_q == lps_pkg::ACT_START_SYS) ? maxp_q[3:0]
                                                              : lps_pkg::USER_Q;
              opri_q     <= (act_q == lps_pkg::ACT_START_SYS) ? maxp_q[3:0]
                                                              : lps_pkg::USER_Q;
              use_q[si]  <= 1'b1;
              emit_q     <= 1'b1;
            end
          end
          lps_pkg::ACT_STOP: begin
            if (!used) ost_q <= lps_pkg::ST_NOT_USE;
            else begin
              use_q[si] <= 1'b0;
              lot_q     <= !sys_q[si] && pri_q[si] >= lps_pkg::WIN_Q;
            end
          end
          lps_pkg::ACT_QUANTUM: begin
            if (!used) ost_q <= lps_pkg::ST_NOT_USE;
            else if (sys_q[si]) begin
              emit_q <= 1'b1;
              if (pri_q[si] < lps_pkg::LOW_SYS_Q) begin
                pri_q[si]  <= pri_q[si] + 4'd1;
                opri_q     <= pri_q[si] + 4'd1;
              end else begin
                opri_q <= pri_q[si];
              end
            end else begin
              lot_q <= 1'b1;
              if (pri_q[si] == lps_pkg::WIN_Q) begin
                pri_q[si] <= lps_pkg::USER_Q;
                opri_q    <= lps_pkg::USER_Q;
                emit_q    <= 1'b1;
              end
            end
          end
          lps_pkg::ACT_NICE: begin
            if (!used) ost_q <= lps_pkg::ST_NOT_USE;
            else begin
              if (nice_sum < 0) tix_q[si] <= '0;
              else if (nice_sum > $signed(NW'(TMAX))) tix_q[si] <= TMAX;
              else tix_q[si] <= nice_sum[TICKET_BITS-1:0];
              opri_q <= pri_q[si];
              emit_q <= 1'b1;
            end
          end
          lps_pkg::ACT_BALANCE: bal_q <= 1'b1;
          default: ;
        endcase
      end
      if (cmd_i.clr_scan) begin
        // decode record already taken
        emit_q  <= 1'b0;
        idx_q   <= '0;
        total_q <= '0;
      end
      if (cmd_i.sum_step) begin
        if (in_lot) total_q <= total_q + TW'(tix_q[ii]);
        idx_q <= idx_q + 1'b1;
      end
      // restoring divide, one quotient bit a cycle; only the remainder is kept
      if (cmd_i.div_start) begin
        rem_q  <= '0;
        dcnt_q <= 6'd0;
        idx_q  <= '0;
      end
      if (cmd_i.div_step) begin
        if (!trial[DW]) rem_q <= trial[DW-1:0];
        else rem_q <= {rem_q[DW-2:0], rnd_q[31]};
        rnd_q  <= {rnd_q[30:0], 1'b0};
        dcnt_q <= dcnt_q + 6'd1;
        if (dcnt_q == 6'd31) begin
          draw_q <= $signed((TW+2)'(trial[DW] ? {rem_q[DW-2:0], rnd_q[31]}
                                              : trial[DW-1:0]))
                    + $signed((TW+2)'(1));
        end
      end
      if (cmd_i.walk_step) begin
        emit_q <= 1'b0;
        if (in_lot && draw_q > 0) begin
          draw_q <= draw_n;
          if (draw_n <= 0) begin
            pri_q[ii] <= lps_pkg::WIN_Q;
            okind_q   <= 1'b0;
            oslot_q   <= 5'(idx_q);
            opri_q    <= lps_pkg::WIN_Q;
            emit_q    <= 1'b1;
          end
        end
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.bal_step) begin
        emit_q <= 1'b0;
        if (bal_hit) begin
          pri_q[ii] <= pri_q[ii] - 4'd1;
          okind_q   <= 1'b0;
          oslot_q   <= 5'(idx_q);
          opri_q    <= pri_q[ii] - 4'd1;
          emit_q    <= 1'b1;
        end
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.set_final) begin
        okind_q <= 1'b1;
        oslot_q <= '0;
        opri_q  <= '0;
      end
    end
  end

  always_comb begin
    stat_o.emit_rec   = emit_q;
    stat_o.go_lottery = lot_q;
    stat_o.go_balance = bal_q;
    stat_o.scan_done  = idx_q == CW'(SLOTS);
    stat_o.total_zero = total_q == '0;
    stat_o.div_done   = dcnt_q == 6'd32;
    stat_o.step_emit  = emit_q;
  end

  assign kind_o         = okind_q;
  assign out_slot_o     = oslot_q;
  assign new_priority_o = opri_q;
  assign status_o       = okind_q ? ost_q : lps_pkg::ST_OK;
  assign last_o         = okind_q;

endmodule
`default_nettype wire

/* rtl/core/lps_ctrl.sv */
`default_nettype none
module lps_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  input  wire lps_pkg::stat_t stat_i,
  output lps_pkg::cmd_t     cmd_o
);

  lps_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lps_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  wire out_take = !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lps_pkg::S_IDLE: if (in_valid_i) state_d = lps_pkg::S_DECODE;
      lps_pkg::S_DECODE: state_d = lps_pkg::S_EMIT;
      lps_pkg::S_EMIT: begin
        // record from decode (if any), then branch
        if (!stat_i.emit_rec || out_take) begin
          if (stat_i.go_lottery) state_d = lps_pkg::S_SUM;
          else if (stat_i.go_balance) state_d = lps_pkg::S_BAL;
          else state_d = lps_pkg::S_FINAL;
        end
      end
      lps_pkg::S_SUM: begin
        if (stat_i.scan_done) begin
          state_d = stat_i.total_zero ? lps_pkg::S_FINAL : lps_pkg::S_DIV;
        end
      end
      lps_pkg::S_DIV: if (stat_i.div_done) state_d = lps_pkg::S_WALK;
      lps_pkg::S_WALK, lps_pkg::S_BAL: begin
        if (!stat_i.step_emit || out_take) begin
          if (stat_i.scan_done) state_d = lps_pkg::S_FINAL;
        end
      end
      lps_pkg::S_FINAL: if (out_take) state_d = lps_pkg::S_IDLE;
      default: state_d = lps_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      lps_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = 1'b1;
      end
      lps_pkg::S_DECODE: cmd_o.decode = 1'b1;
      lps_pkg::S_EMIT: begin
        out_valid_o = stat_i.emit_rec;
        if ((!stat_i.emit_rec || out_take) && stat_i.go_lottery) cmd_o.clr_scan = 1'b1;
        if ((!stat_i.emit_rec || out_take) && stat_i.go_balance) cmd_o.clr_scan = 1'b1;
        if ((!stat_i.emit_rec || out_take) && !stat_i.go_lottery
            && !stat_i.go_balance) cmd_o.set_final = 1'b1;
      end
      lps_pkg::S_SUM: begin
        if (!stat_i.scan_done) cmd_o.sum_step = 1'b1;
        else if (stat_i.total_zero) cmd_o.set_final = 1'b1;
        else cmd_o.div_start = 1'b1;
      end
      lps_pkg::S_DIV: if (!stat_i.div_done) cmd_o.div_step = 1'b1;
      lps_pkg::S_WALK, lps_pkg::S_BAL: begin
        out_valid_o = stat_i.step_emit;
        if (!stat_i.step_emit || out_take) begin
          if (stat_i.scan_done) cmd_o.set_final = 1'b1;
          else if (state_q == lps_pkg::S_WALK) cmd_o.walk_step = 1'b1;
          else cmd_o.bal_step = 1'b1;
        end
      end
      lps_pkg::S_FINAL: out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/lottery_process_scheduler_core.sv */
// A word runs the decode, emit and final states; a balance word also scans all slots.
// A lottery adds a ticket sum, then a bit-serial modulo and walk if any tickets exist.
// One word at a time: a new word is taken only in idle. Each record waits for the
// consumer; stalls extend the run.
// Reset (rst_ni low, async): slot table cleared, initial tickets back to 20.
`default_nettype none
module lottery_process_scheduler_core #(
  parameter int unsigned SLOTS       = 32,
  parameter int unsigned TICKET_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [15:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         action_i,
  input  wire logic [4:0]         slot_i,
  input  wire logic [4:0]         ceil_req_i,
  input  wire logic signed [15:0] nice_delta_i,
  input  wire logic [31:0]        random_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    kind_o,
  output logic [4:0]              out_slot_o,
  output logic [3:0]              new_priority_o,
  output logic [1:0]              status_o,
  output logic                    last_o
);

  lps_pkg::cmd_t  cmd;
  lps_pkg::stat_t stat;

  lps_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  lps_datapath #(.SLOTS(SLOTS), .TICKET_BITS(TICKET_BITS)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .action_i, .slot_i, .ceil_req_i,
    .nice_delta_i, .random_i, .cmd_i(cmd), .stat_o(stat), .kind_o, .out_slot_o,
    .new_priority_o, .status_o, .last_o
  );

endmodule
`default_nettype wire
